// ----- src/interval_cluster_lane_assign_top_assert.svh -----
// Assertion macros for the interval cluster lane assigner.
// Included by the RTL file that checks its own invariants (icla_dp); needs clk and rst_n in scope.
`ifndef INTERVAL_CLUSTER_LANE_ASSIGN_TOP_ASSERT_SVH
`define INTERVAL_CLUSTER_LANE_ASSIGN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ICLA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("icla: invariant violated");
`define ICLA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("icla: next-cycle check violated");
`else
`define ICLA_ASSERT_ALWAYS(lbl, cond)
`define ICLA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- src/icla_pkg.sv -----
// Shared constants, state codes and controller/datapath interface structs
// for the interval cluster lane assigner. No dependencies.
package icla_pkg;

  localparam int MAX_RESULTS       = 64;
  localparam int CLUSTER_DEPTH_DEF = 64;

  localparam int TAG_W   = 16;
  localparam int MIN_W   = 12;  // signed minute on the input side
  localparam int OMIN_W  = 11;  // unsigned minute on the result side
  localparam int LANE_W  = 6;
  localparam int TOTAL_W = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;
  localparam int ENTRY_W = TAG_W + OMIN_W + OMIN_W + LANE_W;

  localparam logic [OMIN_W-1:0] MIN_DUR_RST = 11'd5;
  localparam logic [OMIN_W-1:0] DAY_LEN_RST = 11'd1440;  // 24 * 60
  localparam logic [MIN_W-1:0]  CLUSTER_END_RST = 12'hFFF;  // minus one

  typedef enum logic [0:0] {
    CFG_MIN_DURATION = 1'b0,
    CFG_DAY_LENGTH   = 1'b1
  } cfg_idx_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_EVAL   = 10'b00_0000_0010,
    S_DECIDE = 10'b00_0000_0100,
    S_ERR    = 10'b00_0000_1000,
    S_LRD    = 10'b00_0001_0000,
    S_LCMP   = 10'b00_0010_0000,
    S_PLACE  = 10'b00_0100_0000,
    S_EOB    = 10'b00_1000_0000,
    S_FRD    = 10'b01_0000_0000,
    S_FOUT   = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic load_item;
    logic flush_start;
    logic flush_rd;
    logic flush_emit;
    logic lane_start;
    logic lane_rd;
    logic lane_step;
    logic place;
    logic err_emit;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic item_ok;
    logic brk;
    logic full;
    logic eob;
    logic have_pending;
    logic flush_at_end;
    logic lane_at_new;
    logic lane_busy;
    logic out_free;
  } status_t;

endpackage

// ----- src/icla_ctrl.sv -----
// Controller state machine of the interval cluster lane assigner.
// Depends on icla_pkg; drives the datapath through icla_pkg::cmd_t.
module icla_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  icla_pkg::status_t st,
  output icla_pkg::cmd_t    cmd
);

  icla_pkg::state_t state_r, state_nxt;
  logic brk_flush_r, brk_flush_nxt;  // current flush was caused by a clean break

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= icla_pkg::S_IDLE;
      brk_flush_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      brk_flush_r <= brk_flush_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    brk_flush_nxt = brk_flush_r;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      icla_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = icla_pkg::S_EVAL;
        end
      end
      icla_pkg::S_EVAL: begin
        if (!st.item_ok) begin
          state_nxt = icla_pkg::S_EOB;
        end else if (st.brk) begin
          cmd.flush_start = 1'b1;
          brk_flush_nxt   = 1'b1;
          state_nxt       = icla_pkg::S_FRD;
        end else begin
          state_nxt = icla_pkg::S_DECIDE;
        end
      end
      icla_pkg::S_DECIDE: begin
        if (st.full) begin
          state_nxt = icla_pkg::S_ERR;
        end else begin
          cmd.lane_start = 1'b1;
          state_nxt      = icla_pkg::S_LRD;
        end
      end
      icla_pkg::S_ERR: begin
        if (st.out_free) begin
          cmd.err_emit = 1'b1;
          cmd.last     = !st.eob;
          state_nxt    = icla_pkg::S_EOB;
        end
      end
      icla_pkg::S_LRD: begin
        if (st.lane_at_new) begin
          state_nxt = icla_pkg::S_PLACE;
        end else begin
          cmd.lane_rd = 1'b1;
          state_nxt   = icla_pkg::S_LCMP;
        end
      end
      icla_pkg::S_LCMP: begin
        if (st.lane_busy) begin
          cmd.lane_step = 1'b1;
          state_nxt     = icla_pkg::S_LRD;
        end else begin
          state_nxt = icla_pkg::S_PLACE;
        end
      end
      icla_pkg::S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = icla_pkg::S_EOB;
      end
      icla_pkg::S_EOB: begin
        if (st.eob && st.have_pending) begin
          cmd.flush_start = 1'b1;
          brk_flush_nxt   = 1'b0;
          state_nxt       = icla_pkg::S_FRD;
        end else begin
          state_nxt = icla_pkg::S_IDLE;
        end
      end
      icla_pkg::S_FRD: begin
        cmd.flush_rd = 1'b1;
        state_nxt    = icla_pkg::S_FOUT;
      end
      icla_pkg::S_FOUT: begin
        if (st.out_free) begin
          cmd.flush_emit = 1'b1;
          // A break flush is always followed by a placement, so its final word
          // closes the run only when no end-of-batch flush comes after it.
          cmd.last = st.flush_at_end && (!brk_flush_r || !st.eob);
          if (st.flush_at_end) begin
            state_nxt = brk_flush_r ? icla_pkg::S_DECIDE : icla_pkg::S_IDLE;
          end else begin
            state_nxt = icla_pkg::S_FRD;
          end
        end
      end
      default: state_nxt = icla_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- src/icla_dp.sv -----
// Datapath of the interval cluster lane assigner: configuration registers,
// item registers, lane-end and pending memories, counters and result register.
// Depends on icla_pkg and the assertion macro header.
`include "interval_cluster_lane_assign_top_assert.svh"

module icla_dp #(
  parameter int CAP = icla_pkg::MAX_RESULTS - 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [icla_pkg::OMIN_W-1:0]       cfg_wdata,
  input  logic [icla_pkg::TAG_W-1:0]        item_tag,
  input  logic signed [icla_pkg::MIN_W-1:0] item_start,
  input  logic signed [icla_pkg::MIN_W-1:0] item_end,
  input  logic                              item_eob,
  input  icla_pkg::cmd_t                    cmd,
  output icla_pkg::status_t                 st,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [icla_pkg::TAG_W-1:0]        out_tag,
  output logic [icla_pkg::OMIN_W-1:0]       out_start,
  output logic [icla_pkg::OMIN_W-1:0]       out_duration,
  output logic [icla_pkg::LANE_W-1:0]       out_lane,
  output logic [icla_pkg::TOTAL_W-1:0]      out_total,
  output logic                              out_status,
  output logic                              out_last
);

  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);

  // Configuration
  logic [icla_pkg::OMIN_W-1:0] min_dur_r, day_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dur_r <= icla_pkg::MIN_DUR_RST;
      day_len_r <= icla_pkg::DAY_LEN_RST;
    end else if (cfg_we) begin
      unique case (icla_pkg::cfg_idx_t'(cfg_index))
        icla_pkg::CFG_MIN_DURATION: min_dur_r <= cfg_wdata;
        icla_pkg::CFG_DAY_LENGTH:   day_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Item held while it is worked on
  logic [icla_pkg::TAG_W-1:0]        tag_r;
  logic signed [icla_pkg::MIN_W-1:0] start_r, end_r;
  logic                              eob_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      tag_r   <= item_tag;
      start_r <= item_start;
      end_r   <= item_end;
      eob_r   <= item_eob;
    end
  end

  logic signed [icla_pkg::MIN_W-1:0] day_len_s, span;
  logic [icla_pkg::OMIN_W-1:0]       raw_dur, dur;

  assign day_len_s = $signed({1'b0, day_len_r});
  assign span      = end_r - start_r;
  assign raw_dur   = span[icla_pkg::OMIN_W-1:0];
  assign dur       = (raw_dur < min_dur_r) ? min_dur_r : raw_dur;

  // Cluster state
  logic [CNT_W-1:0]                  pend_cnt_r, lanes_r, flush_idx_r, lane_idx_r;
  logic signed [icla_pkg::MIN_W-1:0] cluster_end_r;
  logic [icla_pkg::TOTAL_W-1:0]      total;

  assign total = (lanes_r == '0) ? icla_pkg::TOTAL_W'(1) : icla_pkg::TOTAL_W'(lanes_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r    <= '0;
      lanes_r       <= '0;
      flush_idx_r   <= '0;
      lane_idx_r    <= '0;
      cluster_end_r <= icla_pkg::CLUSTER_END_RST;
    end else begin
      if (cmd.flush_start) flush_idx_r <= '0;
      if (cmd.lane_start)  lane_idx_r  <= '0;
      if (cmd.lane_step)   lane_idx_r  <= lane_idx_r + 1'b1;
      if (cmd.flush_emit) begin
        flush_idx_r <= flush_idx_r + 1'b1;
        if (st.flush_at_end) begin
          pend_cnt_r    <= '0;
          lanes_r       <= '0;
          cluster_end_r <= icla_pkg::CLUSTER_END_RST;
        end
      end
      if (cmd.place) begin
        pend_cnt_r <= pend_cnt_r + 1'b1;
        if (lane_idx_r == lanes_r) lanes_r <= lanes_r + 1'b1;
        if (end_r > cluster_end_r) cluster_end_r <= end_r;
      end
    end
  end

  // Lane-end memory
  logic [icla_pkg::OMIN_W-1:0] lane_mem [CAP];
  logic [icla_pkg::OMIN_W-1:0] lane_rd_q;

  always_ff @(posedge clk) begin
    if (cmd.place) lane_mem[lane_idx_r[IDX_W-1:0]] <= end_r[icla_pkg::OMIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.lane_rd) lane_rd_q <= lane_mem[lane_idx_r[IDX_W-1:0]];
  end

  // Pending memory: {lane, duration, start, tag}
  logic [icla_pkg::ENTRY_W-1:0] pend_mem [CAP];
  logic [icla_pkg::ENTRY_W-1:0] pend_rd_q;

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      pend_mem[pend_cnt_r[IDX_W-1:0]] <= {icla_pkg::LANE_W'(lane_idx_r), dur,
                                          start_r[icla_pkg::OMIN_W-1:0], tag_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_rd) pend_rd_q <= pend_mem[flush_idx_r[IDX_W-1:0]];
  end

  // Result register
  logic out_vld_r;
  logic load_out;

  assign load_out = cmd.flush_emit || cmd.err_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_emit) begin
      out_tag      <= tag_r;
      out_start    <= start_r[icla_pkg::OMIN_W-1:0];
      out_duration <= dur;
      out_lane     <= '0;
      out_total    <= '0;
      out_status   <= 1'b1;
      out_last     <= cmd.last;
    end else if (cmd.flush_emit) begin
      out_tag      <= pend_rd_q[icla_pkg::TAG_W-1:0];
      out_start    <= pend_rd_q[icla_pkg::TAG_W +: icla_pkg::OMIN_W];
      out_duration <= pend_rd_q[icla_pkg::TAG_W + icla_pkg::OMIN_W +: icla_pkg::OMIN_W];
      out_lane     <= pend_rd_q[icla_pkg::ENTRY_W-1 -: icla_pkg::LANE_W];
      out_total    <= total;
      out_status   <= 1'b0;
      out_last     <= cmd.last;
    end
  end

  assign out_valid = out_vld_r;

  // Status towards the controller
  always_comb begin
    st              = '0;
    st.item_ok      = !start_r[icla_pkg::MIN_W-1] && (end_r <= day_len_s) && (end_r > start_r);
    st.have_pending = (pend_cnt_r != '0);
    st.brk          = st.have_pending && (start_r >= cluster_end_r);
    st.full         = (pend_cnt_r >= CNT_W'(CAP));
    st.eob          = eob_r;
    st.flush_at_end = (flush_idx_r == pend_cnt_r - 1'b1);
    st.lane_at_new  = (lane_idx_r == lanes_r);
    st.lane_busy    = ({1'b0, lane_rd_q} > start_r);
    st.out_free     = !out_vld_r || out_ready;
  end

  `ICLA_ASSERT_ALWAYS(a_pend_cap, pend_cnt_r <= CNT_W'(CAP))
  `ICLA_ASSERT_ALWAYS(a_lanes_le_pend, lanes_r <= pend_cnt_r)
  `ICLA_ASSERT_ALWAYS(a_lane_bound, !cmd.place || (lane_idx_r <= lanes_r))
  `ICLA_ASSERT_NEXT(a_flush_clears, cmd.flush_emit && st.flush_at_end, pend_cnt_r == '0)

endmodule

// ----- src/interval_cluster_lane_assign_top.sv -----
// Interval cluster lane assigner: a placed interval probes the lanes from lane zero, one lane-end
// memory read per probe, until it finds a free lane or, when all lanes are busy, opens a new one;
// an invalid interval is dropped, and each result word of a flush is one read of the pending memory.
// A new input word is taken only in the idle state; one output register decouples the result side.
// Synchronous active-low reset clears the cluster (no lanes, no pending entries, cluster end minus
// one) and sets min_duration to 5 and day_length to 1440; the memories need no clearing.
//
// The design splits into a controller state machine (icla_ctrl) and a datapath (icla_dp).
// Each kept interval first checks for a clean break against the cluster end; a break flushes
// the buffered cluster in arrival order before the new interval is placed. Placement walks the
// lane-end memory from lane zero, one entry per read, until a lane that has ended by the
// interval's start is found or the lane count is reached, in which case a new lane opens.
// A full pending buffer produces a single error word instead. The end-of-batch flag then
// flushes whatever is buffered. The last word caused by one input word carries tlast.
module interval_cluster_lane_assign_top #(
  parameter int CLUSTER_DEPTH = icla_pkg::CLUSTER_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream. tdata from bit 0: event_tag[15:0], start_minute[27:16], end_minute[39:28]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [icla_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,   // end_of_batch
  // Result stream. tdata from bit 0: out_tag[15:0], out_start[26:16], out_duration[37:27],
  // lane_index[43:38], lane_total[50:44], zero padding[55:51]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [icla_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser,  // status: 1 dropped, buffer full
  output logic                               out_tlast,  // last_of_run
  // Configuration write port: index 0 min_duration, index 1 day_length
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [icla_pkg::OMIN_W-1:0]        cfg_wdata
);

  // The buffer never holds more than one word fewer than the largest run of results, so that
  // a flush plus one more word always fits in a single run.
  localparam int Cap = (CLUSTER_DEPTH < icla_pkg::MAX_RESULTS) ? CLUSTER_DEPTH
                                                               : icla_pkg::MAX_RESULTS - 1;
  localparam int PadW = icla_pkg::OUT_DATA_W - icla_pkg::TAG_W - 2 * icla_pkg::OMIN_W
                        - icla_pkg::LANE_W - icla_pkg::TOTAL_W;

  icla_pkg::cmd_t    cmd;
  icla_pkg::status_t st;

  logic [icla_pkg::TAG_W-1:0]   res_tag;
  logic [icla_pkg::OMIN_W-1:0]  res_start, res_dur;
  logic [icla_pkg::LANE_W-1:0]  res_lane;
  logic [icla_pkg::TOTAL_W-1:0] res_total;

  icla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  icla_dp #(
    .CAP (Cap)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .item_tag     (in_tdata[15:0]),
    .item_start   (in_tdata[27:16]),
    .item_end     (in_tdata[39:28]),
    .item_eob     (in_tlast),
    .cmd          (cmd),
    .st           (st),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_tag      (res_tag),
    .out_start    (res_start),
    .out_duration (res_dur),
    .out_lane     (res_lane),
    .out_total    (res_total),
    .out_status   (out_tuser),
    .out_last     (out_tlast)
  );

  assign out_tdata = {{PadW{1'b0}}, res_total, res_lane, res_dur, res_start, res_tag};

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for interval_cluster_lane_assign_top: a directed table, a cluster deep
// enough to overflow, then random sorted interval streams, checked against a predictor or typed rows.
// Depends only on icla_pkg and the RTL of the lane assigner.
module tb_top;
  import icla_pkg::*;

  // Generous bound on the whole run, in clock cycles.
  localparam int LIMIT_CYCLES = 600000;
  // A placed interval may probe every lane before the block is idle again.
  localparam int QUIET_CYCLES = 2 * CLUSTER_DEPTH_DEF + 60;
  // The cluster buffer never holds more than one word short of a full run of results.
  localparam int HOLD_CAP = (CLUSTER_DEPTH_DEF < MAX_RESULTS) ? CLUSTER_DEPTH_DEF
                                                              : MAX_RESULTS - 1;
  localparam int LONG_HOLD = 500;

  typedef struct {
    logic [TAG_W-1:0] tag;
    logic [MIN_W-1:0] start;
    logic [MIN_W-1:0] stop;
    logic             eob;
  } interval_t;

  typedef struct {
    logic [TAG_W-1:0]   tag;
    logic [OMIN_W-1:0]  start;
    logic [OMIN_W-1:0]  dur;
    logic [LANE_W-1:0]  lane;
    logic [TOTAL_W-1:0] total;
    logic               dropped;
    logic               last;
  } placement_t;

  // A directed row is either left to the predictor, or its outcome is typed in: no word at
  // all, or one placed word in lane zero of a single-lane cluster with a given duration.
  typedef enum int { ROW_PREDICT, ROW_SILENT, ROW_SINGLE } row_kind_t;

  typedef struct {
    interval_t         iv;
    row_kind_t         kind;
    logic [OMIN_W-1:0] want_dur;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // event_tag, start_minute, end_minute
  logic                  in_tlast = 1'b0; // end_of_batch
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // out_tag, out_start, out_duration, lane_index,
                                          // lane_total
  logic                  out_tuser;       // status
  logic                  out_tlast;       // last_of_run
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [OMIN_W-1:0]     cfg_wdata = '0;

  interval_cluster_lane_assign_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor state: its own copy of the registers, the lane ends and the open cluster.
  logic [OMIN_W-1:0] min_dur_cfg = MIN_DUR_RST;
  logic [OMIN_W-1:0] day_len_cfg = DAY_LEN_RST;
  logic [OMIN_W-1:0] lane_ends [CLUSTER_DEPTH_DEF];
  int                lanes_open = 0;
  int                cluster_reach = -1;
  placement_t        cluster_words[$];  // buffered cluster, in arrival order
  placement_t        due_words[$];      // result words still to come from the block

  int  errors = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  long_hold_go = 1'b0;
  row_t rows[$];

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  // Emits the whole open cluster, every word carrying the number of lanes it used.
  function automatic void release_cluster();
    placement_t w;
    foreach (cluster_words[i]) begin
      w = cluster_words[i];
      w.total = (lanes_open == 0) ? TOTAL_W'(1) : TOTAL_W'(lanes_open);
      due_words.push_back(w);
    end
    cluster_words.delete();
    lanes_open = 0;
    cluster_reach = -1;
  endfunction

  // Greedy lane assignment for one accepted word; appends the words it causes to due_words
  // and returns 1 when the interval is kept.
  function automatic bit place_interval(interval_t iv);
    int         s;
    int         e;
    int         dur;
    int         lane;
    int         first;
    bit         kept;
    placement_t w;
    s = int'($signed(iv.start));
    e = int'($signed(iv.stop));
    first = due_words.size();
    kept = (s >= 0) && (e <= int'(day_len_cfg)) && (e > s);
    if (kept) begin
      dur = (e - s < int'(min_dur_cfg)) ? int'(min_dur_cfg) : e - s;
      w.tag = iv.tag;
      w.start = OMIN_W'(s);
      w.dur = OMIN_W'(dur);
      w.lane = '0;
      w.total = '0;
      w.dropped = 1'b0;
      w.last = 1'b0;
      // A clean break closes the open cluster before this interval is considered.
      if (cluster_words.size() > 0 && s >= cluster_reach) begin
        release_cluster();
      end
      if (cluster_words.size() >= HOLD_CAP) begin
        // No room left: the interval comes straight back as an error word.
        w.dropped = 1'b1;
        due_words.push_back(w);
      end else begin
        lane = 0;
        while (lane < lanes_open && lane < CLUSTER_DEPTH_DEF && int'(lane_ends[lane]) > s) begin
          lane++;
        end
        if (lane < CLUSTER_DEPTH_DEF) begin
          lane_ends[lane] = OMIN_W'(e);
          if (lane == lanes_open) begin
            lanes_open++;
          end
        end
        if (e > cluster_reach) begin
          cluster_reach = e;
        end
        w.lane = LANE_W'(lane);
        cluster_words.push_back(w);
      end
    end
    if (iv.eob && cluster_words.size() > 0) begin
      release_cluster();
    end
    if (due_words.size() > first) begin
      due_words[due_words.size() - 1].last = 1'b1;
    end
    return kept;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void add_row(logic [TAG_W-1:0] tag, int start, int stop, bit eob,
                                  row_kind_t kind, logic [OMIN_W-1:0] want_dur);
    row_t r;
    r.iv.tag = tag;
    r.iv.start = MIN_W'(start);
    r.iv.stop = MIN_W'(stop);
    r.iv.eob = eob;
    r.kind = kind;
    r.want_dur = want_dur;
    rows.push_back(r);
  endfunction

  // Offers one word, with random idle cycles ahead of it, and predicts its results the
  // moment it is accepted. A typed row replaces whatever the predictor queued for it.
  task automatic send_word(interval_t iv, row_kind_t kind, logic [OMIN_W-1:0] want_dur,
                           output bit kept);
    int         first;
    placement_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {iv.stop, iv.start, iv.tag};
    in_tlast  <= iv.eob;
    do @(posedge clk); while (in_tready !== 1'b1);
    first = due_words.size();
    kept = place_interval(iv);
    if (kind != ROW_PREDICT) begin
      while (due_words.size() > first) begin
        void'(due_words.pop_back());
      end
      if (kind == ROW_SINGLE) begin
        w.tag = iv.tag;
        w.start = iv.start[OMIN_W-1:0];
        w.dur = want_dur;
        w.lane = '0;
        w.total = TOTAL_W'(1);
        w.dropped = 1'b0;
        w.last = 1'b1;
        due_words.push_back(w);
      end
    end
  endtask

  // Lets every expected word come back, then allows for a lane search that ends without
  // a result, so that the block is truly idle afterwards.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic program_limits(logic [OMIN_W-1:0] min_dur, logic [OMIN_W-1:0] day_len);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_DURATION;
    cfg_wdata <= min_dur;
    @(posedge clk);
    cfg_index <= CFG_DAY_LENGTH;
    cfg_wdata <= day_len;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_dur_cfg = min_dur;
    day_len_cfg = day_len;
  endtask

  // Mostly well-formed streams sorted by start, with small steps that build clusters and
  // occasional long jumps that cause clean breaks; about one word in seven is raw noise.
  task automatic run_stream(int goal);
    interval_t iv;
    bit        kept;
    int        n_kept;
    int        n_sent;
    int        cursor;
    int        span;
    int        s;
    int        e;
    int        r;
    n_kept = 0;
    n_sent = 0;
    cursor = 0;
    span = int'(day_len_cfg);
    while (n_kept < goal && n_sent < 4 * goal + 20) begin
      iv.tag = TAG_W'($urandom);
      iv.eob = ($urandom_range(15) == 0);
      if ($urandom_range(99) < 15 || span == 0) begin
        iv.start = MIN_W'($urandom);
        iv.stop = MIN_W'($urandom);
      end else begin
        r = $urandom_range(99);
        if (r < 70) begin
          s = cursor + int'($urandom_range(8));
        end else if (r < 90) begin
          s = cursor + int'($urandom_range(60, 9));
        end else begin
          s = cursor + int'($urandom_range(300, 61));
        end
        if (s >= span) begin
          s = int'($urandom_range((span > 20) ? 20 : span - 1));
        end
        if ($urandom_range(9) == 0) begin
          e = s + int'($urandom_range(400, 1));
        end else begin
          e = s + int'($urandom_range(40, 1));
        end
        if (e > span) begin
          e = span;
        end
        // Now and then the end runs past the day, which must be dropped quietly.
        if ($urandom_range(19) == 0 && span < 2000) begin
          e = span + int'($urandom_range(40, 1));
        end
        cursor = s;
        iv.start = MIN_W'(s);
        iv.stop = MIN_W'(e);
      end
      send_word(iv, ROW_PREDICT, '0, kept);
      n_sent++;
      if (kept) begin
        n_kept++;
      end
    end
  endtask

  // Result side: checks every accepted word against the oldest expectation and decides
  // the ready for the next cycle, including one long hold-off on request.
  initial begin : result_side
    placement_t w;
    int         hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        if (due_words.size() == 0) begin
          $error("result word with no expectation waiting, tag %0h", out_tdata[15:0]);
          errors++;
        end else begin
          w = due_words.pop_front();
          check_field("out_tag", 32'(w.tag), 32'(out_tdata[15:0]));
          check_field("out_start", 32'(w.start), 32'(out_tdata[26:16]));
          check_field("out_duration", 32'(w.dur), 32'(out_tdata[37:27]));
          check_field("lane_index", 32'(w.lane), 32'(out_tdata[43:38]));
          check_field("lane_total", 32'(w.total), 32'(out_tdata[50:44]));
          check_field("status", 32'(w.dropped), 32'(out_tuser));
          check_field("last_of_run", 32'(w.last), 32'(out_tlast));
        end
      end
      if (long_hold_go) begin
        hold_left = LONG_HOLD;
        long_hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    interval_t iv;
    bit        kept;

    // Rows at the reset limits: five minutes minimum, a day of 1440 minutes.
    add_row(16'h0000, 0, 0, 1'b0, ROW_SILENT, '0);        // empty interval
    add_row(16'hFFFF, -1, 10, 1'b0, ROW_SILENT, '0);      // starts before midnight
    add_row(16'h0001, 0, 1441, 1'b0, ROW_SILENT, '0);     // one minute past the day
    add_row(16'h0002, 0, 1440, 1'b1, ROW_SINGLE, 11'd1440); // whole day, flushed at once
    add_row(16'h0003, 10, 12, 1'b1, ROW_SINGLE, 11'd5);   // raised to the minimum
    add_row(16'h0004, -2048, 2047, 1'b1, ROW_SILENT, '0); // invalid, flush of nothing
    add_row(16'h5555, 2047, 2047, 1'b0, ROW_SILENT, '0);
    // A three-lane cluster, closed by an invalid word that carries end of batch.
    add_row(16'd10, 100, 200, 1'b0, ROW_PREDICT, '0);
    add_row(16'd11, 100, 150, 1'b0, ROW_PREDICT, '0);
    add_row(16'd12, 150, 300, 1'b0, ROW_PREDICT, '0);
    add_row(16'd13, 160, 170, 1'b0, ROW_PREDICT, '0);
    add_row(16'd14, 120, 90, 1'b1, ROW_PREDICT, '0);
    // Clean breaks, the last one followed by end of batch on the new interval.
    add_row(16'd20, 400, 500, 1'b0, ROW_PREDICT, '0);
    add_row(16'd21, 450, 460, 1'b0, ROW_PREDICT, '0);
    add_row(16'd22, 500, 600, 1'b0, ROW_PREDICT, '0);
    add_row(16'd23, 600, 700, 1'b1, ROW_PREDICT, '0);
    add_row(16'hFFFF, 1439, 1440, 1'b1, ROW_SINGLE, 11'd5); // last minute of the day
    add_row(16'h8000, 1000, 1000, 1'b1, ROW_SILENT, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_limits(MIN_DUR_RST, DAY_LEN_RST);

    send_idle_pct = 25;
    recv_idle_pct = 51;
    foreach (rows[i]) begin
      send_word(rows[i].iv, rows[i].kind, rows[i].want_dur, kept);
    end

    // Whole-day intervals all overlap, so each opens a lane until the buffer is full; the
    // words after that come back as errors, and the final one also flushes the cluster.
    for (int i = 0; i < HOLD_CAP + 3; i++) begin
      iv.tag = TAG_W'(i);
      iv.start = '0;
      iv.stop = MIN_W'(1440);
      iv.eob = (i == HOLD_CAP + 2);
      send_word(iv, ROW_PREDICT, '0, kept);
    end

    settle();
    program_limits(11'd0, 11'd2047);
    run_stream(20);

    settle();
    program_limits(11'd1440, 11'd1440);
    send_idle_pct = 51;
    recv_idle_pct = 25;
    run_stream(20);

    // No idling, apart from one long hold-off of the result side while words keep coming.
    settle();
    program_limits(11'd2047, 11'd300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_go = 1'b1;
    run_stream(20);

    // A day of zero length: every interval is dropped, end of batch flushes nothing.
    settle();
    program_limits(11'd7, 11'd0);
    run_stream(1);

    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
